@@ src/rau_pkg.sv @@
// ============================================================================
// rau_pkg
// Shared types and constants of the rational arithmetic unit.
// ============================================================================
`default_nettype none

package rau_pkg;

    localparam int OpW   = 31;             // operand numerator width
    localparam int DenW  = OpW - 1;        // operand denominator width
    localparam int MagW  = 62;             // magnitude width of products and sums
    localparam int NumW  = 63;
    localparam int RDenW = 61;
    localparam int WholeW = 62;
    localparam int FracW  = 60;
    localparam int CntW   = 7;             // counts up to MagW

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    // datapath phase commands
    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_LOAD  = 3'd1,   // capture operands
        CMD_MULT  = 3'd2,   // products registered
        CMD_COMB  = 3'd3,   // sum, sign, magnitudes
        CMD_GCD   = 3'd4,   // store divider result: a mod step of Euclid, or quotient/remainder of a job
        CMD_DIV   = 3'd5,   // one restoring division bit
        CMD_DSTRT = 3'd6,   // load divider
        CMD_OUT   = 3'd7    // capture finished item into output register
    } cmd_t;

    typedef struct packed {
        logic done;      // divider finished
        logic gcd_zero;  // current gcd divisor is zero
        logic is_inf;
    } stat_t;

endpackage

`default_nettype wire

@@ src/rau_datapath.sv @@
// ============================================================================
// rau_datapath
// Products, sign handling, Euclid gcd through a shared bit-serial divider,
// reduction and mixed-number split.
// ============================================================================
`default_nettype none

module rau_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire rau_pkg::cmd_t                     cmd,
    input  wire logic [1:0]                        dsel,   // divider job
    input  wire logic [1:0]                        op,
    input  wire logic signed [rau_pkg::OpW-1:0]    left_num,
    input  wire logic [rau_pkg::DenW-1:0]          left_den,
    input  wire logic signed [rau_pkg::OpW-1:0]    right_num,
    input  wire logic [rau_pkg::DenW-1:0]          right_den,
    output rau_pkg::stat_t                         stat,
    output logic [rau_pkg::NumW+rau_pkg::RDenW+rau_pkg::WholeW+rau_pkg::FracW+1:0] result
);

    localparam int M  = rau_pkg::MagW;
    localparam int RW = rau_pkg::NumW + rau_pkg::RDenW + rau_pkg::WholeW
                        + rau_pkg::FracW + 2;

    logic [1:0]                     op_reg;
    logic signed [rau_pkg::OpW-1:0] ln_reg, rn_reg;
    logic [rau_pkg::DenW-1:0]       ld_reg, rd_reg;
    logic signed [M:0]              p1_reg, p2_reg;
    logic signed [M:0]              dp_reg;
    logic [M-1:0]                   un_reg, ud_reg, x_reg, y_reg;
    logic                           neg_reg, inf_reg;
    // divider
    logic [M-1:0]                   dq_reg, dr_reg, dd_reg;
    logic [rau_pkg::CntW-1:0]       dcnt_reg;
    logic [M-1:0]                   nq_reg, whole_reg, frac_reg;
    // output register
    logic [RW-1:0]                  result_reg;

    logic signed [M:0]  sum_c;
    logic [M:0]         trial;
    logic [M-1:0]       rsh;
    logic [M-1:0]       rnum;
    logic [RW-1:0]      res_c;

    // denominator operand for the second product
    logic signed [rau_pkg::OpW:0] rhs_b;
    always_comb
    begin
        sum_c = (op_reg == rau_pkg::OP_SUB) ? p1_reg - p2_reg : p1_reg + p2_reg;
        if (op_reg == rau_pkg::OP_MUL || op_reg == rau_pkg::OP_DIV)
            sum_c = p1_reg;
        rsh   = {dr_reg[M-2:0], dq_reg[M-1]};
        trial = {1'b0, rsh} - {1'b0, dd_reg};
        rhs_b = $signed({2'b00, ld_reg});
    end

    // finished item, is_inf in bit 0
    assign rnum  = neg_reg ? -nq_reg : nq_reg;
    assign res_c = inf_reg ? {{(RW-1){1'b0}}, 1'b1}
        : {frac_reg[rau_pkg::FracW-1:0], whole_reg, neg_reg,
           ud_reg[rau_pkg::RDenW-1:0], {neg_reg, rnum}, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
        end
        else
        begin
            case (cmd)
                rau_pkg::CMD_DSTRT: dcnt_reg <= rau_pkg::CntW'(M);
                rau_pkg::CMD_DIV:   dcnt_reg <= dcnt_reg - 1'b1;
                default:            dcnt_reg <= dcnt_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd)
            rau_pkg::CMD_LOAD:
            begin
                op_reg <= op; ln_reg <= left_num; rn_reg <= right_num;
                ld_reg <= left_den; rd_reg <= right_den;
            end
            rau_pkg::CMD_MULT:
            begin
                case (op_reg)
                    rau_pkg::OP_MUL: p1_reg <= (M+1)'(ln_reg * rn_reg);
                    default:         p1_reg <= (M+1)'(ln_reg * $signed({1'b0, rd_reg}));
                endcase
                p2_reg <= (M+1)'(rn_reg * rhs_b);
                if (op_reg == rau_pkg::OP_DIV)
                    dp_reg <= (M+1)'(rhs_b * rn_reg);
                else
                    dp_reg <= (M+1)'($signed({1'b0, ld_reg}) * $signed({1'b0, rd_reg}));
            end
            rau_pkg::CMD_COMB:
            begin
                un_reg  <= M'(sum_c[M] ? -sum_c : sum_c);
                ud_reg  <= M'(dp_reg[M] ? -dp_reg : dp_reg);
                x_reg   <= M'(sum_c[M] ? -sum_c : sum_c);
                y_reg   <= M'(dp_reg[M] ? -dp_reg : dp_reg);
                inf_reg <= (dp_reg == '0);
                neg_reg <= (sum_c != '0) && (sum_c[M] != dp_reg[M]);
            end
            rau_pkg::CMD_DSTRT:
            begin
                dr_reg <= '0;
                case (dsel)
                    2'd0:    begin dq_reg <= x_reg;  dd_reg <= y_reg;  end
                    2'd1:    begin dq_reg <= un_reg; dd_reg <= x_reg;  end
                    2'd2:    begin dq_reg <= ud_reg; dd_reg <= x_reg;  end
                    default: begin dq_reg <= nq_reg; dd_reg <= ud_reg; end
                endcase
            end
            rau_pkg::CMD_DIV:
            begin
                if (!trial[M])
                begin
                    dr_reg <= trial[M-1:0];
                    dq_reg <= {dq_reg[M-2:0], 1'b1};
                end
                else
                begin
                    dr_reg <= rsh;
                    dq_reg <= {dq_reg[M-2:0], 1'b0};
                end
            end
            rau_pkg::CMD_GCD:
            begin
                // store divider result per job
                case (dsel)
                    2'd0:    begin x_reg <= y_reg; y_reg <= dr_reg; end
                    2'd1:    nq_reg <= dq_reg;
                    2'd2:    ud_reg <= dq_reg;
                    default: begin whole_reg <= dq_reg; frac_reg <= dr_reg; end
                endcase
            end
            rau_pkg::CMD_OUT:
            begin
                result_reg <= res_c;
            end
            default: ;
        endcase
    end

    assign stat.done     = (dcnt_reg == '0);
    assign stat.gcd_zero = (y_reg == '0);
    assign stat.is_inf   = inf_reg;

    assign result = result_reg;

endmodule

`default_nettype wire

@@ src/rau_ctrl.sv @@
// ============================================================================
// rau_ctrl
// Sequencer: operand capture, products, gcd loop, reductions, split.
// ============================================================================
`default_nettype none

module rau_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_fire,
    input  wire logic           out_busy,
    input  wire logic           out_fire,
    input  wire rau_pkg::stat_t stat,
    output rau_pkg::cmd_t       cmd,
    output logic [1:0]          dsel,
    output logic                in_ready,
    output logic                out_valid
);

    typedef enum logic [3:0] {
        S_IDLE, S_MULT, S_COMB, S_GTEST, S_DSTART, S_DRUN, S_DSTORE, S_OUT
    } state_t;

    state_t     state_reg;
    logic [1:0] job_reg;
    logic       ov_reg;
    logic       out_free;

    // output register can take a new item this cycle
    assign out_free = !out_busy || out_fire;

    always_comb
    begin
        cmd = rau_pkg::CMD_NONE;
        case (state_reg)
            S_IDLE:   if (in_fire) cmd = rau_pkg::CMD_LOAD;
            S_MULT:   cmd = rau_pkg::CMD_MULT;
            S_COMB:   cmd = rau_pkg::CMD_COMB;
            S_DSTART: cmd = rau_pkg::CMD_DSTRT;
            S_DRUN:   if (!stat.done) cmd = rau_pkg::CMD_DIV;
            S_DSTORE: cmd = rau_pkg::CMD_GCD;
            S_OUT:    if (out_free) cmd = rau_pkg::CMD_OUT;
            default:  cmd = rau_pkg::CMD_NONE;
        endcase
    end

    assign dsel      = job_reg;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            job_reg   <= 2'd0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (state_reg == S_OUT && out_free)
                ov_reg <= 1'b1;
            else if (out_fire)
                ov_reg <= 1'b0;
            case (state_reg)
                S_IDLE:   if (in_fire) state_reg <= S_MULT;
                S_MULT:   state_reg <= S_COMB;
                S_COMB:   begin job_reg <= 2'd0; state_reg <= S_GTEST; end
                S_GTEST:
                begin
                    if (stat.is_inf)
                        state_reg <= S_OUT;
                    else if (stat.gcd_zero)
                    begin
                        job_reg   <= 2'd1;
                        state_reg <= S_DSTART;
                    end
                    else
                        state_reg <= S_DSTART;
                end
                S_DSTART: state_reg <= S_DRUN;
                S_DRUN:   if (stat.done) state_reg <= S_DSTORE;
                S_DSTORE:
                begin
                    case (job_reg)
                        2'd0:    state_reg <= S_GTEST;
                        2'd3:    state_reg <= S_OUT;
                        default: begin job_reg <= job_reg + 2'd1; state_reg <= S_DSTART; end
                    endcase
                end
                S_OUT:    if (out_free) state_reg <= S_IDLE;
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ src/rational_arithmetic_unit.sv @@
// ============================================================================
// rational_arithmetic_unit
// Rational add/sub/mul/div with gcd reduction and mixed-number split.
// ============================================================================
//  channel | dir | fields
//  s_axis  | in  | tdata: op, left_num, left_den, right_num, right_den
//  m_axis  | out | tdata: res_num, res_den, is_negative, whole_part,
//          |     |        frac_num, is_inf
// One item at a time. Each divider run loads the divider, takes one bit step
// per quotient bit, waits for done and stores the result; a Euclid step adds a
// test state. There are s Euclid steps (at least 1, up to about 87 for 60-bit
// values) before the result is valid, or none for an infinite result; the next
// item can be taken once the result is valid.
// Reset is asynchronous, active low. A result waits in the output register
// while the next item is computed; a finished item stalls until it is free.
`default_nettype none

module rational_arithmetic_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [127:0]  s_axis_tdata,  // op, left_num, left_den, right_num, right_den
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [247:0]       m_axis_tdata   // res_num, res_den, is_negative,
                                              // whole_part, frac_num, is_inf
);

    localparam int RW = rau_pkg::NumW + rau_pkg::RDenW + rau_pkg::WholeW
                        + rau_pkg::FracW + 2;

    rau_pkg::cmd_t  cmd;
    rau_pkg::stat_t stat;
    logic [1:0]     dsel;
    logic [RW-1:0]  res;
    logic           in_fire;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    rau_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_busy(m_axis_tvalid),
        .out_fire(m_axis_tvalid && m_axis_tready), .stat(stat), .cmd(cmd),
        .dsel(dsel), .in_ready(s_axis_tready), .out_valid(m_axis_tvalid)
    );

    rau_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .dsel(dsel),
        .op(s_axis_tdata[1:0]),
        .left_num(s_axis_tdata[32:2]),
        .left_den(s_axis_tdata[62:33]),
        .right_num(s_axis_tdata[93:63]),
        .right_den(s_axis_tdata[123:94]),
        .stat(stat), .result(res)
    );

    // reorder: is_inf ends up in bit 0 of res; place fields low to high
    assign m_axis_tdata = {res[0], res[RW-1:1]};

endmodule

`default_nettype wire

@@ bench/rational_arithmetic_unit_tb.sv @@
// ============================================================================
// rational_arithmetic_unit_tb
// Self-checking bench for the rational add/sub/mul/div unit.
// ============================================================================
// Directed operands (field extremes, each operation, zero results, divide by
// zero, zero denominators) are followed by random rationals of mixed size.
// A clocked driver and monitor apply random gaps and stalls on both streams,
// plus one long output hold-off. Every accepted item is predicted at the
// input and compared field by field with the delivered result.
`default_nettype none

module rational_arithmetic_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int OpW    = rau_pkg::OpW;
    localparam int DenW   = rau_pkg::DenW;
    localparam int NumW   = rau_pkg::NumW;
    localparam int RDenW  = rau_pkg::RDenW;
    localparam int WholeW = rau_pkg::WholeW;
    localparam int FracW  = rau_pkg::FracW;

    localparam int NumRandom = 1430;
    localparam int IdleLimit = 60000;
    localparam int HoldAt    = 300;    // result count that starts the hold-off
    localparam int HoldLen   = 15000;

    typedef struct packed {
        rau_pkg::op_t           op;
        logic signed [OpW-1:0]  lnum;
        logic [DenW-1:0]        lden;
        logic signed [OpW-1:0]  rnum;
        logic [DenW-1:0]        rden;
    } operands_t;

    // highest field first, matching m_axis_tdata
    typedef struct packed {
        logic              inf;
        logic [FracW-1:0]  frac;
        logic [WholeW-1:0] whole;
        logic              neg;
        logic [RDenW-1:0]  den;
        logic [NumW-1:0]   num;
    } quotient_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [247:0] m_axis_tdata;

    operands_t pending_ops[$];
    quotient_t expected_q[$];
    operands_t cur_ops;

    int unsigned errors;
    int unsigned sent, seen, inf_seen, neg_seen;
    int unsigned op_count[4];
    int unsigned send_gap, recv_stall, hold_cnt, idle_cnt;
    logic        hold_done;
    logic        holding;
    logic        quiet;         // stretch with no idling on either side

    rational_arithmetic_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Cross products, sign onto the numerator, gcd reduction, mixed split
    function automatic quotient_t reduce_rational(operands_t a);
        quotient_t         r;
        longint            ln, ld, rn, rd, num, den;
        longint unsigned   un, ud, x, y, t;
        logic              neg;
        r  = '0;
        ln = a.lnum;
        rn = a.rnum;
        ld = longint'(a.lden);
        rd = longint'(a.rden);
        case (a.op)
            rau_pkg::OP_ADD: begin num = ln * rd + rn * ld; den = ld * rd; end
            rau_pkg::OP_SUB: begin num = ln * rd - rn * ld; den = ld * rd; end
            rau_pkg::OP_MUL: begin num = ln * rn;           den = ld * rd; end
            default:         begin num = ln * rd;           den = ld * rn; end
        endcase
        un = (num < 0) ? -num : num;
        ud = (den < 0) ? -den : den;
        if (ud == 0)
        begin
            r.inf = 1'b1;
            return r;
        end
        neg = (un != 0) && ((num < 0) != (den < 0));
        x = un;
        y = ud;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        un = un / x;
        ud = ud / x;
        r.num   = neg ? NumW'(-un) : NumW'(un);
        r.den   = RDenW'(ud);
        r.neg   = neg;
        r.whole = WholeW'(un / ud);
        r.frac  = FracW'(un % ud);
        return r;
    endfunction

    function automatic logic [OpW-1:0] draw_num();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return OpW'($urandom);
            5, 6, 7:       return OpW'(int'($urandom_range(0, 40)) - 20);
            8:             return $urandom_range(0, 1) ? {1'b0, {(OpW-1){1'b1}}}
                                                       : {1'b1, {(OpW-1){1'b0}}};
            default:       return '0;
        endcase
    endfunction

    function automatic logic [DenW-1:0] draw_den();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return DenW'($urandom);
            5, 6, 7:       return DenW'($urandom_range(1, 30));
            8:             return {DenW{1'b1}};
            default:       return ($urandom_range(0, 19) == 0) ? '0 : DenW'(1);
        endcase
    endfunction

    function automatic operands_t mk(rau_pkg::op_t op, int ln, int ld, int rn, int rd);
        operands_t a;
        a.op   = op;
        a.lnum = OpW'(ln);
        a.lden = DenW'(ld);
        a.rnum = OpW'(rn);
        a.rden = DenW'(rd);
        return a;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH result %0d %s: got 0x%0h expected 0x%0h", seen, field, got, want);
        errors++;
    endtask

    // Driver: one item at a time from the pending queue, random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            send_gap      <= 0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            expected_q.push_back(reduce_rational(cur_ops));
            op_count[cur_ops.op]++;
            sent++;
            s_axis_tvalid <= 1'b0;
            send_gap      <= quiet ? 0 : $urandom_range(0, 7);
        end
        else if (!s_axis_tvalid)
        begin
            if (send_gap > 0)
                send_gap <= send_gap - 1;
            else if (pending_ops.size() > 0)
            begin
                cur_ops = pending_ops.pop_front();
                s_axis_tdata  <= {4'b0, cur_ops.rden, cur_ops.rnum, cur_ops.lden,
                                  cur_ops.lnum, cur_ops.op};
                s_axis_tvalid <= 1'b1;
            end
        end
    end

    // Long output hold-off, counted here
    assign holding = (seen >= HoldAt) && !hold_done;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end
        else if (holding)
        begin
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt + 1 >= HoldLen)
                hold_done <= 1'b1;
        end
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        quotient_t got, want;
        int unsigned stall;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_stall    <= 0;
        end
        else
        begin
            stall = (recv_stall > 0) ? recv_stall - 1 : 0;
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (expected_q.size() == 0)
                begin
                    report_mismatch("unexpected", m_axis_tdata[63:0], '0);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.num   !== want.num)   report_mismatch("res_num", got.num, want.num);
                    if (got.den   !== want.den)   report_mismatch("res_den", got.den, want.den);
                    if (got.neg   !== want.neg)   report_mismatch("is_negative", got.neg, want.neg);
                    if (got.whole !== want.whole) report_mismatch("whole_part", got.whole,
                                                                  want.whole);
                    if (got.frac  !== want.frac)  report_mismatch("frac_num", got.frac, want.frac);
                    if (got.inf   !== want.inf)   report_mismatch("is_inf", got.inf, want.inf);
                    if (want.inf) inf_seen++;
                    if (want.neg) neg_seen++;
                end
                seen++;
                stall = quiet ? 0 : $urandom_range(0, 7);
            end
            recv_stall    <= stall;
            m_axis_tready <= (stall == 0) && !holding;
        end
    end

    // Watchdog on cycles without any accepted item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cnt <= 0;
        else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cnt <= 0;
        else if (idle_cnt + 1 >= IdleLimit)
        begin
            $display("timeout: no item moved for %0d cycles", IdleLimit);
            $display("rational_arithmetic_unit test failed");
            $finish;
        end
        else
            idle_cnt <= idle_cnt + 1;
    end

    // Stimulus and end of run
    initial
    begin
        operands_t a;
        int        maxn, minn, maxd;
        errors = 0;
        quiet  = 1'b0;
        maxn   = (1 << (OpW - 1)) - 1;
        minn   = -(1 << (OpW - 1));
        maxd   = (1 << DenW) - 1;
        rst_n  = 1'b0;
        repeat (11) @(posedge clk);
        rst_n  = 1'b1;

        // directed: each op, field extremes, zero result, divide by zero, zero dens
        pending_ops.push_back(mk(rau_pkg::OP_ADD, 1, 2, 1, 3));
        pending_ops.push_back(mk(rau_pkg::OP_SUB, 1, 2, 1, 2));
        pending_ops.push_back(mk(rau_pkg::OP_MUL, -3, 4, 8, 9));
        pending_ops.push_back(mk(rau_pkg::OP_DIV, 5, 6, -10, 3));
        pending_ops.push_back(mk(rau_pkg::OP_ADD, maxn, maxd, maxn, maxd));
        pending_ops.push_back(mk(rau_pkg::OP_ADD, minn, 1, minn, 1));
        pending_ops.push_back(mk(rau_pkg::OP_SUB, minn, maxd, maxn, 1));
        pending_ops.push_back(mk(rau_pkg::OP_MUL, minn, 1, minn, 1));
        pending_ops.push_back(mk(rau_pkg::OP_MUL, maxn, 1, minn, maxd));
        pending_ops.push_back(mk(rau_pkg::OP_DIV, minn, 1, 1, maxd));
        pending_ops.push_back(mk(rau_pkg::OP_DIV, maxn, maxd, minn, 1));
        pending_ops.push_back(mk(rau_pkg::OP_MUL, 0, 7, -5, 3));
        pending_ops.push_back(mk(rau_pkg::OP_DIV, 0, 5, -3, 7));
        pending_ops.push_back(mk(rau_pkg::OP_DIV, 7, 3, 0, 1));
        pending_ops.push_back(mk(rau_pkg::OP_DIV, 0, 1, 0, 1));
        pending_ops.push_back(mk(rau_pkg::OP_ADD, 3, 0, 2, 5));
        pending_ops.push_back(mk(rau_pkg::OP_MUL, 3, 4, 2, 0));
        pending_ops.push_back(mk(rau_pkg::OP_DIV, 3, 0, 2, 5));
        pending_ops.push_back(mk(rau_pkg::OP_SUB, 0, 0, 0, 0));
        pending_ops.push_back(mk(rau_pkg::OP_ADD, -7, 2, 0, 1));
        pending_ops.push_back(mk(rau_pkg::OP_DIV, 9, 1, 3, 1));

        for (int i = 0; i < NumRandom; i++)
        begin
            a.op   = rau_pkg::op_t'($urandom_range(0, 3));
            a.lnum = draw_num();
            a.lden = draw_den();
            a.rnum = draw_num();
            a.rden = draw_den();
            pending_ops.push_back(a);
        end

        // toggle stretches without idling while the queue drains
        while (pending_ops.size() > 0 || s_axis_tvalid)
        begin
            @(posedge clk);
            if (sent % 200 == 150) quiet = 1'b1;
            if (sent % 200 == 0)   quiet = 1'b0;
        end
        while (expected_q.size() > 0) @(posedge clk);
        repeat (7000) @(posedge clk);

        $display("covered %0d items: add %0d, sub %0d, mul %0d, div %0d",
                 sent, op_count[rau_pkg::OP_ADD], op_count[rau_pkg::OP_SUB],
                 op_count[rau_pkg::OP_MUL], op_count[rau_pkg::OP_DIV]);
        $display("%0d results checked, %0d negative, %0d infinite", seen, neg_seen, inf_seen);
        if (errors == 0 && expected_q.size() == 0)
            $display("rational_arithmetic_unit test passed");
        else
            $display("rational_arithmetic_unit test failed");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
src/rau_pkg.sv
src/rau_datapath.sv
src/rau_ctrl.sv
src/rational_arithmetic_unit.sv
bench/rational_arithmetic_unit_tb.sv
